// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the skinning core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hdl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// types, codes and arithmetic helpers of the skinning core
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam logic [2:0] MODE_BIND = 3'd0;
    localparam logic [2:0] MODE_POSE = 3'd1;
    localparam logic [2:0] MODE_VERT = 3'd2;
    localparam logic [2:0] MODE_INFL = 3'd3;
    localparam logic [2:0] MODE_READ = 3'd4;

    localparam int WEIGHT_FRAC = 16;
    localparam int SKIN_ROWS   = 3;

    localparam logic signed [65:0] INT32_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] INT32_MIN_W = -66'sd2147483648;

    typedef enum logic [2:0] {
        K_NOP,
        K_LOAD_BIND,
        K_LOAD_POSE,
        K_LOAD_VERT,
        K_INFL,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [4:0]         bone_index;
        logic [3:0]         element_index;
        logic [9:0]         vertex_index;
        logic signed [31:0] matrix_value;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic signed [31:0] vert_w;
        logic [16:0]        weight;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef struct packed {
        logic clearing;
    } bstat_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_VLOAD,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_M_ADDR,
        ST_M_MUL,
        ST_M_SUM,
        ST_V_ADDR,
        ST_V_MUL,
        ST_V_SUM,
        ST_W_MUL,
        ST_W_SUM,
        ST_MARK,
        ST_DONE
    } state_t;

    function automatic logic sat_ovf(input logic signed [65:0] v);
        return (v > INT32_MAX_W) || (v < INT32_MIN_W);
    endfunction

    function automatic logic signed [31:0] sat_val(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > INT32_MAX_W)
            r = 32'sh7fffffff;
        else if (v < INT32_MIN_W)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: hdl/lbs_front.sv
// ----------------------------------------------------------------------------
// lbs_front
// accepts items and classifies them into back-end commands
// ----------------------------------------------------------------------------
module lbs_front #(
    parameter int MAX_BONES    = 32,
    parameter int MAX_VERTICES = 1024
) (
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         mode,
    input  logic [4:0]         bone_index,
    input  logic [3:0]         element_index,
    input  logic [9:0]         vertex_index,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] vert_x,
    input  logic signed [31:0] vert_y,
    input  logic signed [31:0] vert_z,
    input  logic signed [31:0] vert_w,
    input  logic [16:0]        weight,
    output logic               push,
    output lbs_pkg::cmd_t      cmd
);
    import lbs_pkg::*;

    logic bone_ok;
    logic vtx_ok;

    assign bone_ok = int'(bone_index) < MAX_BONES;
    assign vtx_ok  = int'(vertex_index) < MAX_VERTICES;
    assign push    = start && !busy;

    always_comb
    begin
        cmd.bone_index    = bone_index;
        cmd.element_index = element_index;
        cmd.vertex_index  = vertex_index;
        cmd.matrix_value  = matrix_value;
        cmd.vert_x        = vert_x;
        cmd.vert_y        = vert_y;
        cmd.vert_z        = vert_z;
        cmd.vert_w        = vert_w;
        cmd.weight        = weight;
        // out-of-range indexes and unknown modes become no-ops
        unique case (mode)
            MODE_BIND: cmd.kind = bone_ok ? K_LOAD_BIND : K_NOP;
            MODE_POSE: cmd.kind = bone_ok ? K_LOAD_POSE : K_NOP;
            MODE_VERT: cmd.kind = vtx_ok ? K_LOAD_VERT : K_NOP;
            MODE_INFL: cmd.kind = (bone_ok && vtx_ok) ? K_INFL : K_NOP;
            MODE_READ: cmd.kind = vtx_ok ? K_READ : K_NOP;
            default:   cmd.kind = K_NOP;
        endcase
    end

endmodule

// File: hdl/lbs_queue.sv
// ----------------------------------------------------------------------------
// lbs_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lbs_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lbs_pkg::cmd_t cmd_in,
    input  logic          pop,
    output lbs_pkg::cmd_t cmd_out,
    output lbs_pkg::qstat_t qstat
);
    import lbs_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign cmd_out     = entry_reg[rd_ptr_reg];
    assign qstat.empty = count_reg == 2'd0;
    assign qstat.full  = count_reg == 2'd2;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, !qstat.full)
    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, !qstat.empty)

endmodule

// File: hdl/lbs_back.sv
// ----------------------------------------------------------------------------
// lbs_back
// command sequencer with stores and one shared multiplier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lbs_back #(
    parameter int MAX_BONES    = 32,
    parameter int MAX_VERTICES = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lbs_pkg::cmd_t      cmd_in,
    input  lbs_pkg::qstat_t    qstat,
    output logic               pop,
    output lbs_pkg::bstat_t    bstat,
    output logic               done,
    output logic               is_read,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               saturated
);
    import lbs_pkg::*;

    localparam int BW  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int MAW = BW + 4;
    localparam int VAW = VW + 2;
    localparam logic [VW-1:0] LAST_VTX = VW'(MAX_VERTICES - 1);
    localparam logic signed [65:0] RND_F = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] RND_W = 66'sd1 <<< (WEIGHT_FRAC - 1);

    // stores
    logic signed [31:0] bind_mem [MAX_BONES * 16];
    logic signed [31:0] pose_mem [MAX_BONES * 16];
    logic signed [31:0] vert_mem [MAX_VERTICES * 4];
    logic signed [31:0] acc_mem  [SKIN_ROWS][MAX_VERTICES];
    logic               sat_mem  [MAX_VERTICES];

    logic               bind_we;
    logic               pose_we;
    logic [MAW-1:0]     mat_waddr;
    logic [MAW-1:0]     pose_raddr;
    logic [MAW-1:0]     bind_raddr;
    logic signed [31:0] bind_q;
    logic signed [31:0] pose_q;
    logic               vert_we;
    logic [VAW-1:0]     vert_waddr;
    logic signed [31:0] vert_wdata;
    logic [VAW-1:0]     vert_raddr;
    logic signed [31:0] vert_q;
    logic [2:0]         acc_we;
    logic [VW-1:0]      acc_waddr;
    logic signed [31:0] acc_wdata;
    logic [VW-1:0]      acc_raddr;
    logic signed [31:0] acc_q [SKIN_ROWS];
    logic               sat_we;
    logic               sat_wdata;
    logic               sat_q;

    // sequencer
    state_t             state_reg;
    state_t             state_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [VW-1:0]      clr_reg;
    logic [VW-1:0]      clr_next;
    logic [1:0]         r_reg;
    logic [1:0]         r_next;
    logic [1:0]         c_reg;
    logic [1:0]         c_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    logic               flag_reg;
    logic               flag_next;
    logic signed [65:0] sum_reg;
    logic signed [65:0] sum_next;
    logic signed [65:0] prod_reg;
    logic signed [31:0] m_reg [12];
    logic               m_we;
    logic signed [31:0] t_reg;
    logic signed [31:0] t_next;
    logic               mul_en;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] rnd_f;
    logic signed [65:0] rnd_w;
    logic signed [65:0] s_f;
    logic signed [65:0] s_acc;
    logic               is_read_reg;
    logic               is_read_next;
    logic signed [31:0] out_reg [SKIN_ROWS];
    logic               out_we;
    logic               sat_out_reg;
    logic               sat_out_next;

    logic [BW-1:0]      bone_a;
    logic [VW-1:0]      vtx_a;
    logic [3:0]         m_idx;

    assign bone_a = BW'(cmd_reg.bone_index);
    assign vtx_a  = VW'(cmd_reg.vertex_index);
    assign m_idx  = {r_reg, c_reg};

    assign rnd_f = (prod_reg + RND_F) >>> FRAC_BITS;
    assign rnd_w = (prod_reg + RND_W) >>> WEIGHT_FRAC;
    assign s_f   = sum_reg + rnd_f;
    assign s_acc = 66'(acc_q[r_reg]) + rnd_w;

    assign bstat.clearing = state_reg == ST_CLEAR;
    assign done      = state_reg == ST_DONE;
    assign is_read   = is_read_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign saturated = sat_out_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        clr_next     = clr_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        flag_next    = flag_reg;
        sum_next     = sum_reg;
        t_next       = t_reg;
        is_read_next = is_read_reg;
        sat_out_next = sat_out_reg;
        out_we       = 1'b0;
        m_we         = 1'b0;
        pop          = 1'b0;
        mul_en       = 1'b0;
        mul_a        = 33'(pose_q);
        mul_b        = 33'(bind_q);
        bind_we      = 1'b0;
        pose_we      = 1'b0;
        mat_waddr    = {bone_a, cmd_reg.element_index};
        pose_raddr   = {bone_a, r_reg, k_reg};
        bind_raddr   = {bone_a, k_reg, c_reg};
        vert_we      = 1'b0;
        vert_waddr   = {vtx_a, c_reg};
        vert_raddr   = {vtx_a, c_reg};
        vert_wdata   = cmd_reg.vert_x;
        acc_we       = 3'b000;
        acc_waddr    = vtx_a;
        acc_raddr    = vtx_a;
        acc_wdata    = 32'sd0;
        sat_we       = 1'b0;
        sat_wdata    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                acc_we    = 3'b111;
                acc_waddr = clr_reg;
                sat_we    = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_VTX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop          = 1'b1;
                    cmd_next     = cmd_in;
                    is_read_next = 1'b0;
                    sat_out_next = 1'b0;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                r_next    = 2'd0;
                c_next    = 2'd0;
                k_next    = 2'd0;
                flag_next = 1'b0;
                sum_next  = '0;
                out_we    = 1'b1;
                unique case (cmd_reg.kind)
                    K_LOAD_BIND:
                    begin
                        bind_we    = 1'b1;
                        state_next = ST_DONE;
                    end
                    K_LOAD_POSE:
                    begin
                        pose_we    = 1'b1;
                        state_next = ST_DONE;
                    end
                    K_LOAD_VERT: state_next = ST_VLOAD;
                    K_INFL:      state_next = ST_M_ADDR;
                    K_READ:      state_next = ST_RD_REQ;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_VLOAD:
            begin
                vert_we = 1'b1;
                case (c_reg)
                    2'd0:    vert_wdata = cmd_reg.vert_x;
                    2'd1:    vert_wdata = cmd_reg.vert_y;
                    2'd2:    vert_wdata = cmd_reg.vert_z;
                    default: vert_wdata = cmd_reg.vert_w;
                endcase
                if (c_reg == 2'd0)
                begin
                    acc_we = 3'b111;
                    sat_we = 1'b1;
                end
                c_next = c_reg + 2'd1;
                if (c_reg == 2'd3)
                    state_next = ST_DONE;
            end
            ST_RD_REQ:   state_next = ST_RD_DATA;
            ST_RD_DATA:
            begin
                out_we       = 1'b1;
                is_read_next = 1'b1;
                sat_out_next = sat_q;
                acc_we       = 3'b111;
                sat_we       = 1'b1;
                state_next   = ST_DONE;
            end
            ST_M_ADDR:   state_next = ST_M_MUL;
            ST_M_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_M_SUM;
            end
            ST_M_SUM:
            begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    m_we      = 1'b1;
                    flag_next = flag_reg | sat_ovf(s_f);
                    sum_next  = '0;
                    c_next    = c_reg + 2'd1;
                    if (c_reg == 2'd3)
                    begin
                        if (r_reg == 2'd2)
                        begin
                            r_next     = 2'd0;
                            state_next = ST_V_ADDR;
                        end
                        else
                        begin
                            r_next     = r_reg + 2'd1;
                            state_next = ST_M_ADDR;
                        end
                    end
                    else
                        state_next = ST_M_ADDR;
                end
                else
                begin
                    sum_next   = s_f;
                    state_next = ST_M_ADDR;
                end
            end
            ST_V_ADDR:   state_next = ST_V_MUL;
            ST_V_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = 33'(vert_q);
                mul_b      = 33'(m_reg[m_idx]);
                state_next = ST_V_SUM;
            end
            ST_V_SUM:
            begin
                c_next = c_reg + 2'd1;
                if (c_reg == 2'd3)
                begin
                    t_next     = sat_val(s_f);
                    flag_next  = flag_reg | sat_ovf(s_f);
                    sum_next   = '0;
                    state_next = ST_W_MUL;
                end
                else
                begin
                    sum_next   = s_f;
                    state_next = ST_V_ADDR;
                end
            end
            ST_W_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = 33'(t_reg);
                mul_b      = {16'd0, cmd_reg.weight};
                state_next = ST_W_SUM;
            end
            ST_W_SUM:
            begin
                acc_we[r_reg] = 1'b1;
                acc_wdata     = sat_val(s_acc);
                flag_next     = flag_reg | sat_ovf(s_acc);
                if (r_reg == 2'd2)
                    state_next = ST_MARK;
                else
                begin
                    r_next     = r_reg + 2'd1;
                    state_next = ST_V_ADDR;
                end
            end
            ST_MARK:
            begin
                sat_we     = flag_reg;
                sat_wdata  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            is_read_reg <= 1'b0;
            sat_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            is_read_reg <= is_read_next;
            sat_out_reg <= sat_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        r_reg    <= r_next;
        c_reg    <= c_next;
        k_reg    <= k_next;
        flag_reg <= flag_next;
        sum_reg  <= sum_next;
        t_reg    <= t_next;
        if (mul_en)
            prod_reg <= 66'(mul_a * mul_b);
        if (m_we)
            m_reg[m_idx] <= sat_val(s_f);
        if (out_we)
        begin
            for (int i = 0; i < SKIN_ROWS; i++)
                out_reg[i] <= is_read_next ? acc_q[i] : 32'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bind_we)
            bind_mem[mat_waddr] <= cmd_reg.matrix_value;
        bind_q <= bind_mem[bind_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pose_we)
            pose_mem[mat_waddr] <= cmd_reg.matrix_value;
        pose_q <= pose_mem[pose_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vert_we)
            vert_mem[vert_waddr] <= vert_wdata;
        vert_q <= vert_mem[vert_raddr];
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < SKIN_ROWS; l++)
        begin
            if (acc_we[l])
                acc_mem[l][acc_waddr] <= acc_wdata;
            acc_q[l] <= acc_mem[l][acc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sat_we)
            sat_mem[acc_waddr] <= sat_wdata;
        sat_q <= sat_mem[acc_raddr];
    end

    `ASSERT_IMPLIES(a_no_pop_clear, clk, rst_n, bstat.clearing, !pop)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)

endmodule

// File: hdl/linear_blend_skinning_core.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_core
// fixed-point linear blend skinning engine, one result per item
// ----------------------------------------------------------------------------
// Every accepted item (start high while busy low) yields exactly one result,
// shown for one cycle with done high; the receiver cannot stall, so done must
// be sampled whenever it rises. A read of an in-range vertex returns its
// accumulator with is_read high and clears it; every other item returns an
// all-zero result. After reset the core runs a clearing pass over all
// MAX_VERTICES accumulators and saturation marks with busy high. Loads and
// no-ops pass from dispatch through decode to done, a vertex load writes its
// four coordinates in turn, a read passes a store request and a data step;
// an influence runs on the single shared 33x33 multiplier: 60 matrix and
// vertex products in store read, multiply and accumulate steps each, 3 weight
// products in multiply and accumulate steps, plus dispatch, decode, mark and
// done steps. A two-entry queue lets up to two items wait while one runs.
// ----------------------------------------------------------------------------
module linear_blend_skinning_core #(
    parameter int MAX_BONES    = 32,
    parameter int MAX_VERTICES = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic [4:0]         bone_index,
    input  logic [3:0]         element_index,
    input  logic [9:0]         vertex_index,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] vert_x,
    input  logic signed [31:0] vert_y,
    input  logic signed [31:0] vert_z,
    input  logic signed [31:0] vert_w,
    input  logic [16:0]        weight,
    output logic               done,
    output logic               is_read,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               saturated
);
    import lbs_pkg::*;

    // front to queue
    logic   push;
    cmd_t   push_cmd;
    // queue to back
    cmd_t   head_cmd;
    logic   pop;
    qstat_t qstat;
    bstat_t bstat;

    // hold items off while the queue is full or the stores are being cleared
    assign busy = qstat.full || bstat.clearing;

    lbs_front #(
        .MAX_BONES    (MAX_BONES),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .bone_index    (bone_index),
        .element_index (element_index),
        .vertex_index  (vertex_index),
        .matrix_value  (matrix_value),
        .vert_x        (vert_x),
        .vert_y        (vert_y),
        .vert_z        (vert_z),
        .vert_w        (vert_w),
        .weight        (weight),
        .push          (push),
        .cmd           (push_cmd)
    );

    // short queue so the front keeps taking items while the back works
    lbs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (push_cmd),
        .pop     (pop),
        .cmd_out (head_cmd),
        .qstat   (qstat)
    );

    // back end: stores, shared multiplier and the per-command sequencer
    lbs_back #(
        .MAX_BONES    (MAX_BONES),
        .MAX_VERTICES (MAX_VERTICES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (head_cmd),
        .qstat     (qstat),
        .pop       (pop),
        .bstat     (bstat),
        .done      (done),
        .is_read   (is_read),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated)
    );

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// skinning core testbench
// drives load, influence and read items through the command handshake and
// checks every result against a fixed-point skinning predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import lbs_pkg::*;

    // modes the core treats as no-ops
    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    localparam int NUM_BONES   = 32;
    localparam int NUM_VERTS   = 1024;
    localparam int FRAC        = 16;
    localparam int ITEM_TARGET = 1350;
    localparam int DRAIN_AT    = 700;
    localparam int TAIL_CYCLES = 400;

    typedef struct {
        logic [2:0]         mode;
        logic [4:0]         bone_index;
        logic [3:0]         element_index;
        logic [9:0]         vertex_index;
        logic signed [31:0] matrix_value;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic signed [31:0] vert_w;
        logic [16:0]        weight;
        bit                 drain_first;
    } item_t;

    typedef struct {
        logic               is_read;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } skin_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] mode = '0;
    logic [4:0] bone_index = '0;
    logic [3:0] element_index = '0;
    logic [9:0] vertex_index = '0;
    logic signed [31:0] matrix_value = '0;
    logic signed [31:0] vert_x = '0;
    logic signed [31:0] vert_y = '0;
    logic signed [31:0] vert_z = '0;
    logic signed [31:0] vert_w = '0;
    logic [16:0] weight = '0;
    logic done;
    logic is_read;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic saturated;

    linear_blend_skinning_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .bone_index(bone_index), .element_index(element_index),
        .vertex_index(vertex_index), .matrix_value(matrix_value),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z), .vert_w(vert_w),
        .weight(weight), .done(done), .is_read(is_read),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .saturated(saturated)
    );

    always #5 clk = ~clk;

    item_t        pending_items[$];
    skin_result_t expected_results[$];
    item_t        current_item;

    // predictor copy of the core state
    logic signed [31:0] bind_mat[NUM_BONES*16];
    logic signed [31:0] pose_mat[NUM_BONES*16];
    logic signed [31:0] rest_vert[NUM_VERTS*4];
    logic signed [31:0] accum[NUM_VERTS*3];
    bit                 sat_mark[NUM_VERTS];
    bit                 clip_hit;

    int accepted_count = 0;
    int mismatch_count = 0;
    int influence_count = 0;
    int read_count = 0;
    int saturated_reads = 0;

    // round to nearest by half-add then floor shift
    function automatic longint round_shift(longint p, int s);
        return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > longint'(32'sh7fffffff))
        begin
            clip_hit = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -longint'(64'd2147483648))
        begin
            clip_hit = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // applies one item to the predictor state and returns its result
    function automatic skin_result_t predict_skin(item_t it);
        skin_result_t res;
        logic signed [31:0] m[3][4];
        logic signed [31:0] t;
        longint s;
        int b;
        int v;
        res = '{default: '0};
        b = it.bone_index * 16;
        v = it.vertex_index;
        case (it.mode)
            MODE_BIND: bind_mat[b + it.element_index] = it.matrix_value;
            MODE_POSE: pose_mat[b + it.element_index] = it.matrix_value;
            MODE_VERT:
            begin
                rest_vert[v*4 + 0] = it.vert_x;
                rest_vert[v*4 + 1] = it.vert_y;
                rest_vert[v*4 + 2] = it.vert_z;
                rest_vert[v*4 + 3] = it.vert_w;
                for (int i = 0; i < 3; i++)
                    accum[v*3 + i] = '0;
                sat_mark[v] = 1'b0;
            end
            MODE_INFL:
            begin
                clip_hit = 1'b0;
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 4; c++)
                    begin
                        s = 0;
                        for (int k = 0; k < 4; k++)
                            s += round_shift(longint'(pose_mat[b + r*4 + k]) *
                                             longint'(bind_mat[b + k*4 + c]), FRAC);
                        m[r][c] = clip32(s);
                    end
                for (int r = 0; r < 3; r++)
                begin
                    s = 0;
                    for (int c = 0; c < 4; c++)
                        s += round_shift(longint'(m[r][c]) *
                                         longint'(rest_vert[v*4 + c]), FRAC);
                    t = clip32(s);
                    s = round_shift(longint'(t) * longint'({1'b0, it.weight}),
                                    WEIGHT_FRAC);
                    accum[v*3 + r] = clip32(longint'(accum[v*3 + r]) + s);
                end
                if (clip_hit)
                    sat_mark[v] = 1'b1;
            end
            MODE_READ:
            begin
                res.is_read   = 1'b1;
                res.out_x     = accum[v*3 + 0];
                res.out_y     = accum[v*3 + 1];
                res.out_z     = accum[v*3 + 2];
                res.saturated = sat_mark[v];
                for (int i = 0; i < 3; i++)
                    accum[v*3 + i] = '0;
                sat_mark[v] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // driver: pulls items from the pending queue, holds start until busy
    // is low at an edge, and predicts each accepted item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        bit launch;
        int idle_pct;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            launch = start;
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(),
                                        predict_skin(current_item));
                accepted_count++;
                launch = 1'b0;
            end
            // idle phases rotate every 150 items: none, heavy, none, light
            case ((accepted_count / 150) % 4)
                1: idle_pct = 62;
                3: idle_pct = 28;
                default: idle_pct = 0;
            endcase
            if (!launch && pending_items.size() > 0 &&
                !(pending_items[0].drain_first && expected_results.size() > 0) &&
                $urandom_range(99) >= idle_pct)
            begin
                current_item = pending_items.pop_front();
                mode          <= current_item.mode;
                bone_index    <= current_item.bone_index;
                element_index <= current_item.element_index;
                vertex_index  <= current_item.vertex_index;
                matrix_value  <= current_item.matrix_value;
                vert_x        <= current_item.vert_x;
                vert_y        <= current_item.vert_y;
                vert_z        <= current_item.vert_z;
                vert_w        <= current_item.vert_w;
                weight        <= current_item.weight;
                launch = 1'b1;
            end
            start <= launch;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done strobe is compared with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        skin_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: is_read=%0d x=%0d", is_read, out_x);
            end
            else
            begin
                want = expected_results.pop_front();
                if (is_read) read_count++;
                if (is_read && saturated) saturated_reads++;
                if (is_read !== want.is_read || out_x !== want.out_x ||
                    out_y !== want.out_y || out_z !== want.out_z ||
                    saturated !== want.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp rd=%0d x=%0d y=%0d z=%0d sat=%0d got rd=%0d x=%0d y=%0d z=%0d sat=%0d",
                                 want.is_read, want.out_x, want.out_y, want.out_z,
                                 want.saturated, is_read, out_x, out_y, out_z, saturated);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus generation with a shadow of which entries were written
    // ------------------------------------------------------------------
    bit bind_done[NUM_BONES][16];
    bit pose_done[NUM_BONES][16];
    bit vert_done[NUM_VERTS];
    int forced_weights = 0;

    function automatic item_t random_item();
        item_t it;
        it.mode          = MODE_BIND;
        it.bone_index    = 5'($urandom);
        it.element_index = 4'($urandom);
        it.vertex_index  = 10'($urandom);
        it.matrix_value  = $urandom;
        it.vert_x        = $urandom;
        it.vert_y        = $urandom;
        it.vert_z        = $urandom;
        it.vert_w        = $urandom;
        it.weight        = 17'($urandom);
        it.drain_first   = 1'b0;
        return it;
    endfunction

    // matrix value near the identity scale, sometimes anything
    function automatic logic signed [31:0] mat_value(bit diag);
        if ($urandom_range(99) < 5)
            return $urandom;
        return (diag ? 65536 : 0) + $signed($urandom_range(0, 98304)) - 49152;
    endfunction

    function automatic logic signed [31:0] coord_value();
        if ($urandom_range(99) < 5)
            return $urandom;
        return $signed($urandom_range(0, 2097152)) - 1048576;
    endfunction

    task automatic add_item(item_t it);
        if (it.mode == MODE_BIND) bind_done[it.bone_index][it.element_index] = 1;
        if (it.mode == MODE_POSE) pose_done[it.bone_index][it.element_index] = 1;
        if (it.mode == MODE_VERT) vert_done[it.vertex_index] = 1;
        if (it.mode == MODE_INFL) influence_count++;
        if (pending_items.size() == DRAIN_AT) it.drain_first = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic bit bone_ready(int b);
        for (int e = 0; e < 16; e++)
            if (!bind_done[b][e] || !pose_done[b][e]) return 0;
        return 1;
    endfunction

    task automatic build_stimulus();
        item_t it;
        int ready[$];
        int loaded[$];
        int pick;
        int b;
        // directed: extreme values and codes
        it = random_item(); it.mode = MODE_BIND; it.bone_index = 31;
        it.element_index = 15; it.matrix_value = 32'sh7fffffff; add_item(it);
        it = random_item(); it.mode = MODE_POSE; it.bone_index = 31;
        it.element_index = 0; it.matrix_value = 32'sh80000000; add_item(it);
        it = random_item(); it.mode = MODE_BIND; it.bone_index = 0;
        it.element_index = 0; it.matrix_value = 0; add_item(it);
        it = random_item(); it.mode = MODE_VERT; it.vertex_index = 1023;
        it.vert_x = 32'sh7fffffff; it.vert_y = 32'sh7fffffff;
        it.vert_z = 32'sh7fffffff; it.vert_w = 32'sh7fffffff; add_item(it);
        it = random_item(); it.mode = MODE_VERT; it.vertex_index = 0;
        it.vert_x = 32'sh80000000; it.vert_y = 32'sh80000000;
        it.vert_z = 32'sh80000000; it.vert_w = 32'sh80000000; add_item(it);
        it = random_item(); it.mode = MODE_READ; it.vertex_index = 1023; add_item(it);
        it = random_item(); it.mode = MODE_READ; it.vertex_index = 0; add_item(it);
        // read of a vertex never loaded: accumulator is zero from reset
        it = random_item(); it.mode = MODE_READ; it.vertex_index = 500; add_item(it);
        it = random_item(); it.mode = MODE_SPARE_A; add_item(it);
        it = random_item(); it.mode = MODE_SPARE_B; add_item(it);
        it = random_item(); it.mode = MODE_SPARE_C; add_item(it);
        it = '{default: '1}; it.drain_first = 0; add_item(it);
        it = '{default: '0}; it.mode = MODE_SPARE_A; add_item(it);

        // random: mostly well-formed bone setup, vertex, influence, read
        while (pending_items.size() < ITEM_TARGET)
        begin
            ready.delete();
            loaded.delete();
            for (int i = 0; i < NUM_BONES; i++)
                if (bone_ready(i)) ready.insert(ready.size(), i);
            for (int i = 0; i < NUM_VERTS; i++)
                if (vert_done[i]) loaded.insert(loaded.size(), i);
            pick = $urandom_range(99);
            if (ready.size() == 0 || pick < 4)
            begin
                // load a whole bone, binding and pose interleaved
                b = $urandom_range(NUM_BONES - 1);
                for (int e = 0; e < 16; e++)
                begin
                    it = random_item(); it.mode = MODE_BIND; it.bone_index = 5'(b);
                    it.element_index = 4'(e); it.matrix_value = mat_value(e % 5 == 0);
                    add_item(it);
                    it = random_item(); it.mode = MODE_POSE; it.bone_index = 5'(b);
                    it.element_index = 4'(e); it.matrix_value = mat_value(e % 5 == 0);
                    add_item(it);
                end
            end
            else if (pick < 14)
            begin
                it = random_item();
                it.mode = $urandom_range(1) ? MODE_BIND : MODE_POSE;
                it.bone_index = 5'(ready[$urandom_range(ready.size() - 1)]);
                it.matrix_value = mat_value(it.element_index % 5 == 0);
                add_item(it);
            end
            else if (pick < 30)
            begin
                it = random_item(); it.mode = MODE_VERT;
                if ($urandom_range(3) != 0) it.vertex_index = 10'($urandom_range(15));
                it.vert_x = coord_value(); it.vert_y = coord_value();
                it.vert_z = coord_value();
                it.vert_w = ($urandom_range(3) == 0) ? coord_value() : 32'sd65536;
                add_item(it);
            end
            else if (pick < 72 && loaded.size() > 0)
            begin
                it = random_item(); it.mode = MODE_INFL;
                it.bone_index = 5'(ready[$urandom_range(ready.size() - 1)]);
                it.vertex_index = 10'(loaded[$urandom_range(loaded.size() - 1)]);
                if (forced_weights == 0) it.weight = 0;
                else if (forced_weights == 1) it.weight = 17'h1ffff;
                else if ($urandom_range(9) != 0) it.weight = 17'($urandom_range(65536));
                forced_weights++;
                add_item(it);
            end
            else if (pick < 96)
            begin
                it = random_item(); it.mode = MODE_READ;
                if (loaded.size() > 0 && $urandom_range(3) != 0)
                    it.vertex_index = 10'(loaded[$urandom_range(loaded.size() - 1)]);
                add_item(it);
            end
            else
            begin
                it = random_item();
                it.mode = 3'(MODE_SPARE_A + $urandom_range(2));
                add_item(it);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence: reset once, build items, wait out the tail, report
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NUM_VERTS*3; i++) accum[i] = '0;
        for (int i = 0; i < NUM_VERTS; i++) sat_mark[i] = 1'b0;
        build_stimulus();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // all items handed over and the last one accepted
        while (pending_items.size() > 0 || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d items, %0d influences, %0d reads (%0d saturated)",
                 accepted_count, influence_count, read_count, saturated_reads);
        $display("mismatches: %0d, results still expected: %0d",
                 mismatch_count, expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lbs_pkg.sv
hdl/lbs_front.sv
hdl/lbs_queue.sv
hdl/lbs_back.sv
hdl/linear_blend_skinning_core.sv
dv/testbench.sv
